### design/bounded_lifo_stack_engine_unit_macros.svh
// Assertion macros shared by the stack engine RTL.
// Depends on nothing; expects clk and rst to be visible where it is used.
`ifndef BOUNDED_LIFO_STACK_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_LIFO_STACK_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BLSE_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define BLSE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BLSE_CHECK(label, cond, msg)
`define BLSE_CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

### design/blse_pkg.sv
// Package for the stack engine: widths, command and status codes, operation type.
// Used by every RTL file of the block but blse_ram and the macro header; depends on nothing.
`default_nettype none
package blse_pkg;

  localparam int WORD_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 3;
  localparam int DEPTH_DEFAULT = 256;
  localparam int CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);
  localparam int IDX_W_DEFAULT = (DEPTH_DEFAULT > 1) ? $clog2(DEPTH_DEFAULT) : 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SIZE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_POS  = 3'd4;

  // Operation as classified by the front end; OP_NOP covers the unused code.
  typedef enum logic [2:0] {
    OP_INIT,
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_SIZE,
    OP_CLEAR,
    OP_SEARCH,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [WORD_W-1:0] value;
  } op_head_t;

endpackage
`default_nettype wire

### design/blse_if.sv
// Handshake interfaces for the command and response words of the stack engine.
// Depends on blse_pkg.
`default_nettype none
interface blse_cmd_if #(
  parameter int CNT_W = blse_pkg::CNT_W_DEFAULT
);
  logic                              valid;
  logic                              ready;
  logic [blse_pkg::CMD_W-1:0]        command;
  logic signed [blse_pkg::WORD_W-1:0] push_value;
  logic [CNT_W-1:0]                  search_position;

  modport source (output valid, output command, output push_value,
                  output search_position, input ready);
  modport sink (input valid, input command, input push_value,
                input search_position, output ready);
endinterface

interface blse_rsp_if #(
  parameter int CNT_W = blse_pkg::CNT_W_DEFAULT,
  parameter int IDX_W = blse_pkg::IDX_W_DEFAULT
);
  logic                              valid;
  logic                              ready;
  logic [blse_pkg::STATUS_W-1:0]     status;
  logic signed [blse_pkg::WORD_W-1:0] word_out;
  logic [CNT_W-1:0]                  entry_count;
  logic [IDX_W-1:0]                  found_index;

  modport source (output valid, output status, output word_out,
                  output entry_count, output found_index, input ready);
  modport sink (input valid, input status, input word_out,
                input entry_count, input found_index, output ready);
endinterface
`default_nettype wire

### design/blse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module blse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                           clk,
  input  wire logic                                           wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]                               wr_data,
  input  wire logic                                           rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]                               rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

### design/blse_front.sv
// Front end: accepts command words and classifies them into operations.
// Depends on blse_pkg and blse_cmd_if; feeds blse_queue.
`default_nettype none
module blse_front #(
  parameter int CNT_W = blse_pkg::CNT_W_DEFAULT,
  parameter int QW    = $bits(blse_pkg::op_head_t) + CNT_W
) (
  blse_cmd_if.sink             cmd,
  output logic                 wr_valid,
  input  wire logic            wr_ready,
  output logic [QW-1:0]        wr_data
);
  blse_pkg::op_head_t head;

  always_comb begin
    head.value = cmd.push_value;
    case (cmd.command)
      blse_pkg::CMD_INIT:   head.op = blse_pkg::OP_INIT;
      blse_pkg::CMD_PUSH:   head.op = blse_pkg::OP_PUSH;
      blse_pkg::CMD_POP:    head.op = blse_pkg::OP_POP;
      blse_pkg::CMD_PEEK:   head.op = blse_pkg::OP_PEEK;
      blse_pkg::CMD_SIZE:   head.op = blse_pkg::OP_SIZE;
      blse_pkg::CMD_CLEAR:  head.op = blse_pkg::OP_CLEAR;
      blse_pkg::CMD_SEARCH: head.op = blse_pkg::OP_SEARCH;
      default:              head.op = blse_pkg::OP_NOP;
    endcase
  end

  assign wr_valid  = cmd.valid;
  assign cmd.ready = wr_ready;
  assign wr_data   = {head, cmd.search_position};
endmodule
`default_nettype wire

### design/blse_queue.sv
// Short register queue that decouples the front end from the execution back end.
// Depends on blse_pkg and the assertion macros.
`default_nettype none
`include "bounded_lifo_stack_engine_unit_macros.svh"
module blse_queue #(
  parameter int W = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire logic [W-1:0]  wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output logic [W-1:0]       rd_data
);
  localparam int PW = (blse_pkg::QUEUE_DEPTH > 1) ? $clog2(blse_pkg::QUEUE_DEPTH) : 1;
  localparam int OW = $clog2(blse_pkg::QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] FULL_OCC = OW'(blse_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(blse_pkg::QUEUE_DEPTH - 1);

  logic [W-1:0]  entries [blse_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [OW-1:0] occ;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (occ != FULL_OCC);
  assign rd_valid = (occ != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   occ <= occ + OW'(1);
        2'b01:   occ <= occ - OW'(1);
        default: occ <= occ;
      endcase
    end
  end

  `BLSE_CHECK(a_occ_bounded, occ <= FULL_OCC, "queue occupancy above its depth")
endmodule
`default_nettype wire

### design/blse_back.sv
// Back end: executes stack operations against the word store and holds the response.
// Depends on blse_pkg, blse_rsp_if and the assertion macros; drives blse_ram.
`default_nettype none
`include "bounded_lifo_stack_engine_unit_macros.svh"
module blse_back #(
  parameter int DEPTH = blse_pkg::DEPTH_DEFAULT,
  parameter int CNT_W = blse_pkg::CNT_W_DEFAULT,
  parameter int IDX_W = blse_pkg::IDX_W_DEFAULT,
  parameter int QW    = $bits(blse_pkg::op_head_t) + CNT_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire logic [QW-1:0]               q_data,
  output logic                             wr_en,
  output logic [IDX_W-1:0]                 wr_addr,
  output logic [blse_pkg::WORD_W-1:0]      wr_data,
  output logic                             rd_en,
  output logic [IDX_W-1:0]                 rd_addr,
  input  wire logic [blse_pkg::WORD_W-1:0] rd_data,
  blse_rsp_if.source                       rsp
);
  localparam int HW = $bits(blse_pkg::op_head_t);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_KEY, S_SCAN} state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic                       ready_flag;
  logic [blse_pkg::WORD_W-1:0] key;
  logic [IDX_W-1:0]           cmp_idx;
  logic [IDX_W-1:0]           key_idx;

  blse_pkg::op_head_t q_head;
  logic [CNT_W-1:0]   q_pos;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   pos_m1;
  logic               slot_free;
  logic               take;
  logic               is_empty;
  logic               is_full;
  logic               pos_ok;

  assign q_head    = blse_pkg::op_head_t'(q_data[QW-1 -: HW]);
  assign q_pos     = q_data[CNT_W-1:0];
  assign cnt_m1    = count - ONE;
  assign pos_m1    = q_pos - ONE;
  assign is_empty  = (count == '0);
  assign is_full   = (count == DEPTH_C);
  assign pos_ok    = (q_pos != '0) && (q_pos <= count);
  assign slot_free = !rsp.valid || rsp.ready;
  assign q_ready   = (state == S_IDLE) && slot_free;
  assign take      = q_valid && q_ready;

  assign wr_en   = take && (q_head.op == blse_pkg::OP_PUSH) && ready_flag && !is_full;
  assign wr_addr = count[IDX_W-1:0];
  assign wr_data = q_head.value;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_m1[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (take && !is_empty) begin
          if ((q_head.op == blse_pkg::OP_POP && ready_flag) ||
              q_head.op == blse_pkg::OP_PEEK) begin
            rd_en = 1'b1;
          end else if (q_head.op == blse_pkg::OP_SEARCH && pos_ok) begin
            rd_en   = 1'b1;
            rd_addr = pos_m1[IDX_W-1:0];
          end
        end
      end
      S_KEY: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = cmp_idx + IDX_W'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ready_flag <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            rsp.status      <= blse_pkg::ST_OK;
            rsp.word_out    <= '0;
            rsp.entry_count <= count;
            rsp.found_index <= '0;
            rsp.valid       <= 1'b1;
            case (q_head.op)
              blse_pkg::OP_INIT: begin
                ready_flag      <= 1'b1;
                count           <= '0;
                rsp.entry_count <= '0;
              end
              blse_pkg::OP_PUSH: begin
                if (!ready_flag) begin
                  rsp.status <= blse_pkg::ST_NOT_INIT;
                end else if (is_full) begin
                  rsp.status <= blse_pkg::ST_FULL;
                end else begin
                  count           <= count + ONE;
                  rsp.entry_count <= count + ONE;
                end
              end
              blse_pkg::OP_POP: begin
                if (!ready_flag) begin
                  rsp.status <= blse_pkg::ST_NOT_INIT;
                end else if (is_empty) begin
                  rsp.status <= blse_pkg::ST_EMPTY;
                end else begin
                  count     <= cnt_m1;
                  rsp.valid <= 1'b0;
                  state     <= S_READ;
                end
              end
              blse_pkg::OP_PEEK: begin
                if (is_empty) begin
                  rsp.status <= blse_pkg::ST_EMPTY;
                end else begin
                  rsp.valid <= 1'b0;
                  state     <= S_READ;
                end
              end
              blse_pkg::OP_SIZE: begin
                if (is_empty) begin
                  rsp.status <= blse_pkg::ST_EMPTY;
                end
              end
              blse_pkg::OP_CLEAR: begin
                if (is_empty) begin
                  rsp.status <= blse_pkg::ST_EMPTY;
                end else begin
                  count           <= '0;
                  rsp.entry_count <= '0;
                end
              end
              blse_pkg::OP_SEARCH: begin
                if (is_empty) begin
                  rsp.status <= blse_pkg::ST_EMPTY;
                end else if (!pos_ok) begin
                  rsp.status <= blse_pkg::ST_BAD_POS;
                end else begin
                  key_idx   <= pos_m1[IDX_W-1:0];
                  rsp.valid <= 1'b0;
                  state     <= S_KEY;
                end
              end
              default: begin
                rsp.status <= blse_pkg::ST_OK;
              end
            endcase
          end
        end
        S_READ: begin
          rsp.status      <= blse_pkg::ST_OK;
          rsp.word_out    <= rd_data;
          rsp.entry_count <= count;
          rsp.found_index <= '0;
          rsp.valid       <= 1'b1;
          state           <= S_IDLE;
        end
        S_KEY: begin
          key     <= rd_data;
          cmp_idx <= '0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_data == key) begin
            rsp.status      <= blse_pkg::ST_OK;
            rsp.word_out    <= '0;
            rsp.entry_count <= count;
            rsp.found_index <= cmp_idx;
            rsp.valid       <= 1'b1;
            state           <= S_IDLE;
          end else begin
            cmp_idx <= cmp_idx + IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BLSE_CHECK(a_count_bounded, count <= DEPTH_C, "stack count above depth")
  `BLSE_CHECK(a_scan_in_range, (state != S_SCAN) || (cmp_idx <= key_idx), "search ran past key")
  `BLSE_CHECK_NEXT(a_push_grows, wr_en, count == $past(count) + ONE, "push did not grow stack")
endmodule
`default_nettype wire

### design/bounded_lifo_stack_engine_unit.sv
// A command passes the queue register and the response register of the back end; pop and peek
// add the word store read, and search adds a key read and a scan up to the matched index.
// Throughput: one command a cycle for single-step commands while responses are taken;
// pop and peek hold the back end until the store read returns; search scans one entry a cycle.
// Reset (synchronous, active high) empties the stack and clears the initialised flag;
// the word store is not cleared and no clearing pass runs.
`default_nettype none
module bounded_lifo_stack_engine_unit #(
  parameter int DEPTH = blse_pkg::DEPTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  blse_cmd_if.sink   cmd,
  blse_rsp_if.source rsp
);
  // The count needs one more code than the depth; store indexes cover the depth only.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = $bits(blse_pkg::op_head_t) + CNT_W;

  // Queue write side, from the front end.
  logic          fq_valid;
  logic          fq_ready;
  logic [QW-1:0] fq_data;

  // Queue read side, towards the back end.
  logic          qb_valid;
  logic          qb_ready;
  logic [QW-1:0] qb_data;

  // Word store ports, driven by the back end.
  logic                          ram_wr_en;
  logic [IDX_W-1:0]              ram_wr_addr;
  logic [blse_pkg::WORD_W-1:0]   ram_wr_data;
  logic                          ram_rd_en;
  logic [IDX_W-1:0]              ram_rd_addr;
  logic [blse_pkg::WORD_W-1:0]   ram_rd_data;

  // The front end only decodes the command code, so a word is taken whenever the
  // queue has room, even while the back end is still busy with a search.
  blse_front #(
    .CNT_W (CNT_W),
    .QW    (QW)
  ) u_front (
    .cmd      (cmd),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data)
  );

  blse_queue #(
    .W (QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // The back end owns the count and the initialised flag, and holds each response
  // in its output register until it is taken.
  blse_back #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W),
    .QW    (QW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_data  (qb_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .rsp     (rsp)
  );

  // Word store: every read whose data is used lies below the count, so it hits a pushed word.
  blse_ram #(
    .WIDTH (blse_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );
endmodule
`default_nettype wire
